/* rtl/rcspwm_pkg.sv */
package rcspwm_pkg;

  localparam int unsigned CHANNEL_SLOTS_DEF = 8;
  localparam int unsigned PERIOD_US_DEF     = 20000;
  localparam int unsigned DUTY_BITS_DEF     = 14;

  localparam int unsigned PULSE_W     = 16;
  localparam int unsigned APPLIED_W   = 15;
  localparam int unsigned CHAN_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  // percent offset / 100 as (x * PCT_RECIP) >> PCT_SHIFT, exact for x < 2^23
  localparam int unsigned PCT_PROD_W = 23;
  localparam logic [23:0] PCT_RECIP  = 24'd10737419;
  localparam int unsigned PCT_SHIFT  = 30;

  localparam logic [47:0] CAL_RESET  = 48'd8590032897000;
  localparam logic [11:0] PINS_RESET = 12'd324;
  localparam logic [2:0]  FLAGS_RESET = 3'd0;
  localparam logic [63:0] MASK_RESET = '1;

  localparam logic [2:0] CFG_STEER_CAL = 3'd0;
  localparam logic [2:0] CFG_THR_CAL   = 3'd1;
  localparam logic [2:0] CFG_PINS      = 3'd2;
  localparam logic [2:0] CFG_FLAGS     = 3'd3;
  localparam logic [2:0] CFG_MASK      = 3'd4;

  localparam logic [1:0] REQ_RAW      = 2'd0;
  localparam logic [1:0] REQ_RELEASE  = 2'd1;
  localparam logic [1:0] REQ_STEER    = 2'd2;
  localparam logic [1:0] REQ_THROTTLE = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FORBIDDEN   = 3'd1;
  localparam logic [2:0] ST_NO_CHANNEL  = 3'd2;
  localparam logic [2:0] ST_PCT_RANGE   = 3'd3;
  localparam logic [2:0] ST_PULSE_RANGE = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd5;
  localparam logic [2:0] ST_NOT_LOADED  = 3'd6;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  typedef enum logic [1:0] {
    OP_DRIVE,
    OP_RELEASE,
    OP_FAIL
  } op_e;

  typedef struct packed {
    logic [47:0] steer_cal;
    logic [47:0] thr_cal;
    logic [11:0] pins;
    logic [2:0]  flags;
    logic [63:0] mask;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [2:0]         status;
    logic [5:0]         pin;
    logic [PULSE_W-1:0] pulse;
  } cmd_t;

endpackage

/* rtl/rcspwm_front.sv */
module rcspwm_front
  import rcspwm_pkg::*;
#(
  parameter int unsigned PERIOD_MICROSECONDS = PERIOD_US_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         pin_i,
  input  logic [15:0]        pulse_width_i,
  input  logic signed [7:0]  percent_i,
  input  logic               clamp_mode_i,
  output logic               push_o,
  output cmd_t               cmd_o,
  input  logic               full_i
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_DIV  = 3'd2;
  localparam logic [2:0] F_MAP  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  localparam logic [PULSE_W-1:0] Period = PULSE_W'(PERIOD_MICROSECONDS);

  logic [2:0] state_q, state_d;
  cmd_t cmd_q, cmd_d;
  logic [6:0]  mag_q, mag_d;
  logic [15:0] mid_q, mid_d, end_q, end_d;
  logic [PCT_PROD_W-1:0] prod_q;
  logic dneg_q;
  logic [15:0] quo_q;

  logic accept;
  logic [47:0] cal;
  logic rev;
  logic signed [8:0] pct, pc;
  logic pct_bad;
  logic [15:0] dmag;
  logic [46:0] recip_prod;
  logic signed [17:0] offset, mapped;

  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign cmd_o      = cmd_q;

  always_comb begin
    cal = (req_type_i == REQ_STEER) ? cfg_i.steer_cal : cfg_i.thr_cal;
    rev = (req_type_i == REQ_STEER) ? cfg_i.flags[0] : cfg_i.flags[1];
    pct = 9'(percent_i);
    pct_bad = 1'b0;
    if (clamp_mode_i) begin
      pc = pct;
      if (pct < -9'sd100) pc = -9'sd100;
      if (pct > 9'sd100) pc = 9'sd100;
      if (rev) pc = -pc;
    end else begin
      pc = rev ? -pct : pct;
      pct_bad = (pc < -9'sd100) || (pc > 9'sd100);
    end
    mag_d = (pc < 0) ? 7'(-pc) : 7'(pc);
    mid_d = cal[31:16];
    end_d = (pc < 0) ? cal[15:0] : cal[47:32];
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    dmag    = (end_q < mid_q) ? (mid_q - end_q) : (end_q - mid_q);
    recip_prod = {24'd0, prod_q} * {23'd0, PCT_RECIP};
    offset  = dneg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    mapped  = $signed({2'b00, mid_q}) + offset;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          cmd_d.status = ST_OK;
          cmd_d.pin    = pin_i;
          cmd_d.pulse  = pulse_width_i;
          state_d      = F_PUSH;
          unique case (req_type_i)
            REQ_RAW: begin
              cmd_d.op = OP_DRIVE;
              if (pulse_width_i > Period) begin
                cmd_d.op     = OP_FAIL;
                cmd_d.status = ST_PULSE_RANGE;
              end
            end
            REQ_RELEASE: cmd_d.op = OP_RELEASE;
            default: begin
              cmd_d.op  = OP_DRIVE;
              cmd_d.pin = (req_type_i == REQ_STEER) ? cfg_i.pins[5:0] : cfg_i.pins[11:6];
              if (clamp_mode_i && !cfg_i.flags[2]) begin
                cmd_d.op     = OP_FAIL;
                cmd_d.status = ST_NOT_LOADED;
              end else if (pct_bad) begin
                cmd_d.op     = OP_FAIL;
                cmd_d.status = ST_PCT_RANGE;
              end else begin
                state_d = F_MUL;
              end
            end
          endcase
        end
      end
      F_MUL: state_d = F_DIV;
      F_DIV: state_d = F_MAP;
      F_MAP: begin
        if (mapped < 0) cmd_d.pulse = '0;
        else if (mapped > $signed({2'b00, Period})) cmd_d.pulse = Period;
        else cmd_d.pulse = mapped[15:0];
        state_d = F_PUSH;
      end
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (accept) begin
      mag_q <= mag_d;
      mid_q <= mid_d;
      end_q <= end_d;
    end
    if (state_q == F_MUL) begin
      prod_q <= PCT_PROD_W'({7'd0, dmag} * {16'd0, mag_q});
      dneg_q <= (end_q < mid_q);
    end
    if (state_q == F_DIV) quo_q <= recip_prod[PCT_SHIFT+15:PCT_SHIFT];
  end

endmodule

/* rtl/rcspwm_fifo.sv */
module rcspwm_fifo
  import rcspwm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t word_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t word_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign word_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= word_i;
  end

endmodule

/* rtl/rcspwm_back.sv */
module rcspwm_back
  import rcspwm_pkg::*;
#(
  parameter int unsigned CHANNEL_SLOTS       = CHANNEL_SLOTS_DEF,
  parameter int unsigned PERIOD_MICROSECONDS = PERIOD_US_DEF,
  parameter int unsigned DUTY_BITS           = DUTY_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [63:0]          mask_i,
  input  logic                 empty_i,
  input  cmd_t                 cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [1:0]           drive_action_o,
  output logic [CHAN_W-1:0]    channel_o,
  output logic                 new_channel_o,
  output logic [DUTY_BITS-1:0] duty_o,
  output logic [APPLIED_W-1:0] applied_pulse_o
);

  localparam int unsigned SlotW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
  localparam longint unsigned DutyMax = (64'd1 << DUTY_BITS) - 64'd1;
  localparam longint unsigned DutyInt = DutyMax / PERIOD_MICROSECONDS;
  localparam longint unsigned DutyRem = DutyMax % PERIOD_MICROSECONDS;
  localparam longint unsigned Recip   = (64'd1 << 32) / PERIOD_MICROSECONDS;
  localparam logic [PULSE_W-1:0] Period = PULSE_W'(PERIOD_MICROSECONDS);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL1 = 3'd1;
  localparam logic [2:0] B_MUL2 = 3'd2;
  localparam logic [2:0] B_MUL3 = 3'd3;
  localparam logic [2:0] B_FIX  = 3'd4;
  localparam logic [2:0] B_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic [5:0] slot_pin_q [CHANNEL_SLOTS];
  logic [CHANNEL_SLOTS-1:0] slot_used_q;

  logic [2:0]           res_status_q;
  logic [1:0]           res_act_q;
  logic [SlotW-1:0]     res_slot_q;
  logic                 res_new_q;
  logic [PULSE_W-1:0]   res_pulse_q;
  logic [DUTY_BITS-1:0] res_duty_q;

  logic [31:0]          x2_q;
  logic [DUTY_BITS-1:0] pa_q;
  logic [15:0]          q0_q;
  logic [31:0]          qp_q;

  logic                 out_valid_q;
  logic [2:0]           status_q;
  logic [1:0]           act_q;
  logic [SlotW-1:0]     chan_q;
  logic                 new_q;
  logic [DUTY_BITS-1:0] duty_q;
  logic [PULSE_W-1:0]   pulse_q;

  logic                 hit, has_free, load_out;
  logic [SlotW-1:0]     hit_idx, free_idx;
  logic [63:0]          t_prod;
  logic [31:0]          rem;
  logic [15:0]          quo;

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign load_out = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = CHANNEL_SLOTS - 1; i >= 0; i--) begin
      if (slot_used_q[i] && (slot_pin_q[i] == cmd_i.pin)) begin
        hit     = 1'b1;
        hit_idx = SlotW'(i);
      end
      if (!slot_used_q[i]) begin
        has_free = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  always_comb begin
    t_prod = {32'd0, x2_q} * {32'd0, 32'(Recip)};
    rem    = x2_q - qp_q;
    quo    = q0_q + 16'((rem >= {16'd0, Period}) ? 1 : 0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_DONE;
          if ((cmd_i.op == OP_DRIVE) && mask_i[cmd_i.pin] && (hit || has_free)) begin
            state_d = B_MUL1;
          end
        end
      end
      B_MUL1: state_d = B_MUL2;
      B_MUL2: state_d = B_MUL3;
      B_MUL3: state_d = B_FIX;
      B_FIX:  state_d = B_DONE;
      B_DONE: if (load_out) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      slot_used_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        if (cmd_i.op == OP_RELEASE && hit) begin
          slot_used_q[hit_idx] <= 1'b0;
        end else if (cmd_i.op == OP_DRIVE && mask_i[cmd_i.pin] && !hit && has_free) begin
          slot_used_q[free_idx] <= 1'b1;
        end
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_status_q <= ST_OK;
      res_act_q    <= ACT_NONE;
      res_slot_q   <= '0;
      res_new_q    <= 1'b0;
      res_pulse_q  <= '0;
      res_duty_q   <= '0;
      unique case (cmd_i.op)
        OP_RELEASE: begin
          if (hit) begin
            res_act_q  <= ACT_STOP;
            res_slot_q <= hit_idx;
          end else begin
            res_status_q <= ST_NOT_FOUND;
          end
        end
        OP_DRIVE: begin
          if (!mask_i[cmd_i.pin]) begin
            res_status_q <= ST_FORBIDDEN;
          end else if (hit) begin
            res_act_q   <= ACT_SET;
            res_slot_q  <= hit_idx;
            res_pulse_q <= cmd_i.pulse;
          end else if (has_free) begin
            res_act_q   <= ACT_SET;
            res_slot_q  <= free_idx;
            res_new_q   <= 1'b1;
            res_pulse_q <= cmd_i.pulse;
            slot_pin_q[free_idx] <= cmd_i.pin;
          end else begin
            res_status_q <= ST_NO_CHANNEL;
          end
        end
        default: res_status_q <= cmd_i.status;
      endcase
    end
    // duty = p * int(D/P) + floor(p * rem(D/P) / P), the second term by reciprocal
    if (state_q == B_MUL1) begin
      x2_q <= 32'({16'd0, res_pulse_q} * 32'(DutyRem));
      pa_q <= DUTY_BITS'({{DUTY_BITS{1'b0}}, res_pulse_q} *
                         (DUTY_BITS+PULSE_W)'(DutyInt));
    end
    if (state_q == B_MUL2) q0_q <= t_prod[47:32];
    if (state_q == B_MUL3) qp_q <= {16'd0, q0_q} * {16'd0, Period};
    if (state_q == B_FIX) res_duty_q <= pa_q + DUTY_BITS'(quo);
    if (load_out) begin
      status_q <= res_status_q;
      act_q    <= res_act_q;
      chan_q   <= res_slot_q;
      new_q    <= res_new_q;
      duty_q   <= res_duty_q;
      pulse_q  <= res_pulse_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign drive_action_o  = act_q;
  assign channel_o       = CHAN_W'(chan_q);
  assign new_channel_o   = new_q;
  assign duty_o          = duty_q;
  assign applied_pulse_o = APPLIED_W'(pulse_q);

endmodule

/* rtl/rc_servo_pwm_commander.sv */
// Servo / ESC pulse commander.
// Input channel (in_valid_i / in_stall_o): one command word per handshake:
// raw pulse on a pin, release a pin, steer percent or throttle percent.
// Output channel (out_valid_o / out_stall_i): one result word per command,
// in command order, with status, drive action, channel, duty and pulse.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 steer cal, 1 throttle cal, 2 pin numbers, 3 flags, 4 allowed mask).
// The front end takes a new word only in idle: raw, release and failed
// commands go straight to push, percent commands pass F_MUL, F_DIV and F_MAP
// first (a multiply by the magnitude, then one by a constant reciprocal for
// the /100 mapping). A 4-word queue feeds the back end, which binds the slot
// table as it pops a word; a drive then runs the duty scaling through B_MUL1,
// B_MUL2, B_MUL3 and B_FIX, and every command ends in B_DONE, which loads the
// output register. Sustained rate is set by the back end.
// Reset clears the slot table valid bits and restores register defaults.
// While the receiver stalls, the result holds in the output register; the
// back end finishes one more command and the queue fills, then in_stall_o
// stays high.
module rc_servo_pwm_commander
  import rcspwm_pkg::*;
#(
  parameter int unsigned CHANNEL_SLOTS       = CHANNEL_SLOTS_DEF,
  parameter int unsigned PERIOD_MICROSECONDS = PERIOD_US_DEF,
  parameter int unsigned DUTY_BITS           = DUTY_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [5:0]           pin_i,
  input  logic [15:0]          pulse_width_i,
  input  logic signed [7:0]    percent_i,
  input  logic                 clamp_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [1:0]           drive_action_o,
  output logic [CHAN_W-1:0]    channel_o,
  output logic                 new_channel_o,
  output logic [DUTY_BITS-1:0] duty_o,
  output logic [APPLIED_W-1:0] applied_pulse_o
);

  cfg_t cfg_q;
  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steer_cal <= CAL_RESET;
      cfg_q.thr_cal   <= CAL_RESET;
      cfg_q.pins      <= PINS_RESET;
      cfg_q.flags     <= FLAGS_RESET;
      cfg_q.mask      <= MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEER_CAL: cfg_q.steer_cal <= cfg_data_i[47:0];
        CFG_THR_CAL:   cfg_q.thr_cal   <= cfg_data_i[47:0];
        CFG_PINS:      cfg_q.pins      <= cfg_data_i[11:0];
        CFG_FLAGS:     cfg_q.flags     <= cfg_data_i[2:0];
        CFG_MASK:      cfg_q.mask      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rcspwm_front #(
    .PERIOD_MICROSECONDS(PERIOD_MICROSECONDS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .pin_i,
    .pulse_width_i,
    .percent_i,
    .clamp_mode_i,
    .push_o       (push),
    .cmd_o        (cmd_in),
    .full_i       (full)
  );

  rcspwm_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .word_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .word_o  (cmd_out),
    .empty_o (empty)
  );

  rcspwm_back #(
    .CHANNEL_SLOTS      (CHANNEL_SLOTS),
    .PERIOD_MICROSECONDS(PERIOD_MICROSECONDS),
    .DUTY_BITS          (DUTY_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .mask_i   (cfg_q.mask),
    .empty_i  (empty),
    .cmd_i    (cmd_out),
    .pop_o    (pop),
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .drive_action_o,
    .channel_o,
    .new_channel_o,
    .duty_o,
    .applied_pulse_o
  );

endmodule

/* rtl/rcspwm_chk.sv */
module rcspwm_chk
  import rcspwm_pkg::*;
#(
  parameter int unsigned PERIOD_MICROSECONDS = PERIOD_US_DEF,
  parameter int unsigned DUTY_BITS           = DUTY_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [2:0]           status_o,
  input logic [1:0]           drive_action_o,
  input logic [CHAN_W-1:0]    channel_o,
  input logic                 new_channel_o,
  input logic [DUTY_BITS-1:0] duty_o,
  input logic [APPLIED_W-1:0] applied_pulse_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(drive_action_o) && $stable(channel_o) && $stable(duty_o) &&
      $stable(applied_pulse_o) && $stable(new_channel_o))
    else $error("result word changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (drive_action_o == ACT_NONE) &&
      (channel_o == '0) && !new_channel_o && (duty_o == '0) && (applied_pulse_o == '0))
    else $error("failed command carries a payload");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (drive_action_o == ACT_STOP) |-> (status_o == ST_OK) &&
      !new_channel_o && (duty_o == '0) && (applied_pulse_o == '0))
    else $error("stop carries duty or pulse");

  a_ok_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> (drive_action_o == ACT_SET) ||
      (drive_action_o == ACT_STOP))
    else $error("ok result without an action");

  a_pulse_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (drive_action_o == ACT_SET) && (PERIOD_MICROSECONDS < (1 << APPLIED_W))
      |-> ({1'b0, applied_pulse_o} <= (APPLIED_W+1)'(PERIOD_MICROSECONDS)))
    else $error("applied pulse beyond the period");

endmodule

bind rc_servo_pwm_commander rcspwm_chk #(
  .PERIOD_MICROSECONDS(PERIOD_MICROSECONDS),
  .DUTY_BITS          (DUTY_BITS)
) u_rcspwm_chk (.*);

/* tb/sv/tb.sv */
module tb;
  import rcspwm_pkg::*;

  localparam int NUM_SLOTS = CHANNEL_SLOTS_DEF;
  localparam longint PERIOD_US = PERIOD_US_DEF;
  localparam longint DUTY_MAX = (64'd1 << DUTY_BITS_DEF) - 1;
  localparam longint PCT_LIMIT = 100;
  localparam int POOL_SIZE = 12;
  localparam int MAX_REPORTS = 10;

  localparam int FLAG_STEER_REV = 0;
  localparam int FLAG_THR_REV = 1;
  localparam int FLAG_LOADED = 2;

  localparam int RX_FREE = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;
  localparam int RX_TOGGLE = 3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [5:0]        pin;
    logic [15:0]       pulse;
    logic signed [7:0] percent;
    logic              clamp;
  } servo_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  action;
    logic [2:0]  channel;
    logic        fresh;
    logic [13:0] duty;
    logic [14:0] pulse;
  } servo_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [5:0]  pin = '0;
  logic [15:0] pulse_width = '0;
  logic signed [7:0] percent = '0;
  logic        clamp_mode = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [1:0]  drive_action;
  logic [2:0]  channel;
  logic        new_channel;
  logic [13:0] duty;
  logic [14:0] applied_pulse;

  // mirror of the slot table and registers
  logic        slot_busy [NUM_SLOTS];
  logic [5:0]  slot_owner [NUM_SLOTS];
  logic [47:0] cal_steer;
  logic [47:0] cal_throttle;
  logic [11:0] rc_pins;
  logic [2:0]  rc_flags;
  logic [63:0] pin_allow;

  servo_result_t pending_results[$];
  logic [5:0] pin_pool [POOL_SIZE];
  int mismatches = 0;
  bit tx_gaps_on = 1'b1;
  int burst_left = 0;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int rx_mode = RX_FREE;
  int rx_mode_left = 0;

  rc_servo_pwm_commander i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .pin_i          (pin),
    .pulse_width_i  (pulse_width),
    .percent_i      (percent),
    .clamp_mode_i   (clamp_mode),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .drive_action_o (drive_action),
    .channel_o      (channel),
    .new_channel_o  (new_channel),
    .duty_o         (duty),
    .applied_pulse_o(applied_pulse)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int find_slot(logic [5:0] p);
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (slot_busy[i] && slot_owner[i] == p) return i;
    end
    return -1;
  endfunction

  function automatic servo_result_t drive_slot(logic [5:0] p, longint req_pulse);
    servo_result_t r = '0;
    int s;
    int i;
    longint up;
    if (!pin_allow[p]) begin
      r.status = ST_FORBIDDEN;
      return r;
    end
    s = find_slot(p);
    if (s < 0) begin
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_busy[i]) begin
          s = i;
          break;
        end
      end
      if (s < 0) begin
        r.status = ST_NO_CHANNEL;
        return r;
      end
      slot_busy[s] = 1'b1;
      slot_owner[s] = p;
      r.fresh = 1'b1;
    end
    up = req_pulse;
    if (up < 0) up = 0;
    if (up > PERIOD_US) up = PERIOD_US;
    r.status = ST_OK;
    r.action = ACT_SET;
    r.channel = 3'(s);
    r.duty = 14'((up * DUTY_MAX) / PERIOD_US);
    r.pulse = 15'(up);
    return r;
  endfunction

  function automatic servo_result_t map_percent(logic [47:0] cal, bit reversed, logic [5:0] p,
                                                longint pct, bit clamp);
    servo_result_t r = '0;
    longint lo;
    longint mid;
    longint hi;
    if (clamp) begin
      if (!rc_flags[FLAG_LOADED]) begin
        r.status = ST_NOT_LOADED;
        return r;
      end
      if (pct < -PCT_LIMIT) pct = -PCT_LIMIT;
      if (pct > PCT_LIMIT) pct = PCT_LIMIT;
      if (reversed) pct = -pct;
    end else begin
      if (reversed) pct = -pct;
      if (pct < -PCT_LIMIT || pct > PCT_LIMIT) begin
        r.status = ST_PCT_RANGE;
        return r;
      end
    end
    lo = longint'(cal[15:0]);
    mid = longint'(cal[31:16]);
    hi = longint'(cal[47:32]);
    if (pct < 0) return drive_slot(p, mid + ((lo - mid) * (-pct)) / PCT_LIMIT);
    return drive_slot(p, mid + ((hi - mid) * pct) / PCT_LIMIT);
  endfunction

  function automatic servo_result_t servo_outcome(servo_cmd_t c);
    servo_result_t r = '0;
    int s;
    longint pct;
    pct = longint'($signed(c.percent));
    case (c.kind)
      REQ_RAW: begin
        if (longint'(c.pulse) > PERIOD_US) r.status = ST_PULSE_RANGE;
        else r = drive_slot(c.pin, longint'(c.pulse));
      end
      REQ_RELEASE: begin
        s = find_slot(c.pin);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          slot_busy[s] = 1'b0;
          r.action = ACT_STOP;
          r.channel = 3'(s);
        end
      end
      REQ_STEER: r = map_percent(cal_steer, rc_flags[FLAG_STEER_REV], rc_pins[5:0], pct,
                                 c.clamp);
      default: r = map_percent(cal_throttle, rc_flags[FLAG_THR_REV], rc_pins[11:6], pct,
                               c.clamp);
    endcase
    return r;
  endfunction

  function automatic string fmt_result(servo_result_t r);
    return $sformatf("status=%0d action=%0d channel=%0d new=%0d duty=%0d pulse=%0d",
                     r.status, r.action, r.channel, r.fresh, r.duty, r.pulse);
  endfunction

  function automatic servo_cmd_t servo_cmd(logic [1:0] k, logic [5:0] p, logic [15:0] pw,
                                           int pct, bit cl);
    servo_cmd_t c;
    c.kind = k;
    c.pin = p;
    c.pulse = pw;
    c.percent = 8'(pct);
    c.clamp = cl;
    return c;
  endfunction

  function automatic servo_cmd_t random_cmd();
    servo_cmd_t c;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 7) c.kind = REQ_RAW;
    else if (pick < 12) c.kind = REQ_RELEASE;
    else if (pick < 16) c.kind = REQ_STEER;
    else c.kind = REQ_THROTTLE;
    if ($urandom_range(0, 4) != 0) c.pin = pin_pool[$urandom_range(0, POOL_SIZE - 1)];
    else c.pin = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0: c.pulse = 16'd0;
      1: c.pulse = 16'(PERIOD_US);
      2: c.pulse = 16'($urandom_range(PERIOD_US + 1, 65535));
      3: c.pulse = 16'hFFFF;
      default: c.pulse = 16'($urandom_range(0, PERIOD_US));
    endcase
    case ($urandom_range(0, 7))
      0, 1: c.percent = 8'($urandom_range(0, 255));
      2: c.percent = ($urandom_range(0, 1) != 0) ? 8'(PCT_LIMIT) : 8'(-PCT_LIMIT);
      3: c.percent = ($urandom_range(0, 1) != 0) ? 8'(PCT_LIMIT + 1) : 8'(-PCT_LIMIT - 1);
      default: c.percent = 8'(int'($urandom_range(0, 200)) - 100);
    endcase
    c.clamp = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic logic [63:0] random_cal();
    logic [15:0] lo;
    logic [15:0] mid;
    logic [15:0] hi;
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2, 3: begin
        lo = 16'($urandom_range(500, 1500));
        mid = 16'($urandom_range(1200, 1800));
        hi = 16'($urandom_range(1500, 2500));
        return {16'($urandom), hi, mid, lo};
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] random_mask();
    case ($urandom_range(0, 5))
      0, 1, 2: return '1;
      3: return ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
      4: return {$urandom, $urandom};
      default: return ~({$urandom, $urandom} & {$urandom, $urandom});
    endcase
  endfunction

  task automatic send_cmd(servo_cmd_t c);
    bit ready;
    req_type <= c.kind;
    pin <= c.pin;
    pulse_width <= c.pulse;
    percent <= c.percent;
    clamp_mode <= c.clamp;
    in_valid <= 1'b1;
    ready = 1'b0;
    while (!ready) begin
      @(negedge clk_i);
      ready = !in_stall;
      @(posedge clk_i);
    end
    pending_results.push_back(servo_outcome(c));
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEER_CAL: cal_steer = data[47:0];
      CFG_THR_CAL:   cal_throttle = data[47:0];
      CFG_PINS:      rc_pins = data[11:0];
      CFG_FLAGS:     rc_flags = data[2:0];
      CFG_MASK:      pin_allow = data;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [63:0] steer, logic [63:0] thr, logic [11:0] pins,
                                logic [2:0] flags, logic [63:0] mask);
    wait_results();
    write_reg(CFG_STEER_CAL, steer);
    write_reg(CFG_THR_CAL, thr);
    write_reg(CFG_PINS, {52'd0, pins});
    write_reg(CFG_FLAGS, {61'd0, flags});
    write_reg(CFG_MASK, mask);
  endtask

  task automatic run_random_phase(int n);
    int i;
    logic [11:0] pins;
    for (i = 0; i < 3; i++) pin_pool[$urandom_range(0, POOL_SIZE - 1)] = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 3) != 0) pins = {pin_pool[1], pin_pool[0]};
    else pins = 12'($urandom);
    write_all_regs(random_cal(), random_cal(), pins, 3'($urandom_range(0, 7)), random_mask());
    tx_gaps_on = ($urandom_range(0, 3) != 0);
    repeat (n) send_cmd(random_cmd());
  endtask

  task automatic test_commands_at_reset();
    send_cmd(servo_cmd(REQ_RAW, 6'd0, 16'd0, 0, 1'b0));
    send_cmd(servo_cmd(REQ_RAW, 6'd63, 16'(PERIOD_US), 0, 1'b0));
    send_cmd(servo_cmd(REQ_RAW, 6'd63, 16'(PERIOD_US + 1), 0, 1'b0));
    send_cmd(servo_cmd(REQ_RAW, 6'd0, 16'hFFFF, 0, 1'b1));
    send_cmd(servo_cmd(REQ_STEER, 6'd0, 16'd0, 0, 1'b0));
    send_cmd(servo_cmd(REQ_THROTTLE, 6'd0, 16'd0, -100, 1'b0));
    send_cmd(servo_cmd(REQ_STEER, 6'd0, 16'd0, 100, 1'b0));
    send_cmd(servo_cmd(REQ_THROTTLE, 6'd0, 16'd0, 101, 1'b0));
    send_cmd(servo_cmd(REQ_STEER, 6'd0, 16'd0, -128, 1'b0));
    send_cmd(servo_cmd(REQ_STEER, 6'd0, 16'd0, 127, 1'b1));
    send_cmd(servo_cmd(REQ_RELEASE, 6'd0, 16'd0, 0, 1'b0));
    send_cmd(servo_cmd(REQ_RELEASE, 6'd0, 16'd0, 0, 1'b0));
  endtask

  task automatic test_slot_table();
    int p;
    for (p = 10; p <= 15; p++) send_cmd(servo_cmd(REQ_RAW, 6'(p), 16'(p * 1000), 0, 1'b0));
    send_cmd(servo_cmd(REQ_RELEASE, 6'd12, 16'd0, 0, 1'b0));
    send_cmd(servo_cmd(REQ_RAW, 6'd15, 16'd1234, 0, 1'b0));
    send_cmd(servo_cmd(REQ_RAW, 6'd63, 16'd777, 0, 1'b0));
  endtask

  task automatic test_mask_and_flags();
    wait_results();
    write_reg(CFG_MASK, ~((64'd1 << 20) | (64'd1 << 13)));
    write_reg(CFG_FLAGS, 64'd7);
    write_reg(CFG_STEER_CAL, 64'h0000_FFFF_0000_FFFF);
    write_reg(CFG_THR_CAL, '1);
    send_cmd(servo_cmd(REQ_STEER, 6'd0, 16'd0, -128, 1'b1));
    send_cmd(servo_cmd(REQ_STEER, 6'd0, 16'd0, -128, 1'b0));
    send_cmd(servo_cmd(REQ_THROTTLE, 6'd0, 16'd0, 127, 1'b1));
    send_cmd(servo_cmd(REQ_RAW, 6'd20, 16'd100, 0, 1'b0));
    send_cmd(servo_cmd(REQ_RAW, 6'd13, 16'd30000, 0, 1'b0));
    send_cmd(servo_cmd(REQ_RELEASE, 6'd13, 16'd0, 0, 1'b0));
  endtask

  task automatic test_config_extremes();
    write_all_regs('1, '0, 12'hFFF, 3'd7, '1);
    repeat (60) send_cmd(random_cmd());
    write_all_regs('0, '1, 12'h000, 3'd0, '0);
    repeat (30) send_cmd(random_cmd());
  endtask

  task automatic test_random_mix();
    repeat (12) run_random_phase(105);
  endtask

  task automatic test_receiver_hold();
    wait_results();
    tx_gaps_on = 1'b0;
    rx_hold_req = 250;
    repeat (60) send_cmd(random_cmd());
  endtask

  task automatic test_sender_pause();
    repeat (5) begin
      tx_gaps_on = ($urandom_range(0, 1) != 0);
      repeat (25) send_cmd(random_cmd());
      wait_results();
    end
  endtask

  // receiver stall pattern; a hold request overrides it
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(RX_FREE, RX_TOGGLE);
        rx_mode_left = $urandom_range(4, 64);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= !out_stall;
      endcase
    end
  end

  always @(negedge clk_i) begin : result_check
    servo_result_t got;
    servo_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      got = {status, drive_action, channel, new_channel, duty, applied_pulse};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result word: %s", fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result mismatch: expected %s", fmt_result(want));
            $display("                 got      %s", fmt_result(got));
          end
        end
      end
    end
  end

  initial begin
    int waited;
    int i;
    cal_steer = CAL_RESET;
    cal_throttle = CAL_RESET;
    rc_pins = PINS_RESET;
    rc_flags = FLAGS_RESET;
    pin_allow = MASK_RESET;
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_owner[i] = '0;
    end
    pin_pool = '{6'd0, 6'd63, 6'd4, 6'd5, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd20,
                 6'd30};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands_at_reset();
    test_slot_table();
    test_mask_and_flags();
    test_config_extremes();
    test_random_mix();
    test_receiver_hold();
    test_sender_pause();

    if (in_valid) in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (30) @(posedge clk_i);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rcspwm_pkg.sv
rtl/rcspwm_front.sv
rtl/rcspwm_fifo.sv
rtl/rcspwm_back.sv
rtl/rc_servo_pwm_commander.sv
rtl/rcspwm_chk.sv
tb/sv/tb.sv
